// ----- hw/rtl/sgfd_pkg.sv -----
`timescale 1ns / 1ps

package sgfd_pkg;

  localparam int unsigned CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CARD_BASE    = 3'd0,
    REG_START_OFFSET = 3'd1,
    REG_TOTAL_LENGTH = 3'd2,
    REG_PLANE_WIDTH  = 3'd3,
    REG_CHROMA_PLANE = 3'd4,
    REG_RING_BASE    = 3'd5
  } sgfd_reg_e;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_SHORT    = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  localparam logic [31:0] CTRL_CHROMA  = 32'h4861_000F;
  localparam logic [31:0] CTRL_LUMA    = 32'h08BE_100F;
  localparam logic [7:0]  LINES_CHROMA = 8'd8;
  localparam logic [7:0]  LINES_LUMA   = 8'd16;
  localparam logic [2:0]  GEOM_SWAP    = 3'd3;
  localparam logic [63:0] RING_ALIGN   = 64'd31;

  typedef struct packed {
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic        first_seg;
    logic        table_end;
  } sgfd_in_t;

  typedef struct packed {
    logic        desc_valid;
    logic [7:0]  desc_index;
    logic [31:0] desc_ctrl;
    logic [31:0] desc_len;
    logic [63:0] desc_host_addr;
    logic [63:0] desc_card_addr;
    logic [63:0] desc_next;
    logic        desc_last;
    logic [1:0]  status;
  } sgfd_out_t;

endpackage

// ----- hw/rtl/sg_frame_descriptor_builder_core.sv -----
`timescale 1ns / 1ps

// Scatter-gather frame descriptor chain builder.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one scatter element
// per word; first_seg starts a new transfer from the programmed registers.
// Output channel (out_valid_o / out_stall_i / out_data_o) gives at most one
// word per element: a descriptor, or an error word with desc_valid low.
// Registers are written through cfg_we_i / cfg_idx_i / cfg_data_i while the
// block is idle; the user must ensure this, the block does not enforce it.
// ring_base is aligned up to 32 bytes as it is written. An accepted element
// is held in the input register; its result is computed combinationally and
// registered into the result register. Throughput is one element per cycle
// unless the receiver stalls, set by the single compute stage between them.
// When the receiver stalls, the result register holds its word, the element
// behind it waits in the input register and in_stall_o rises.
// Reset clears the registers, the transfer state and both valid flags.
module sg_frame_descriptor_builder_core #(
  parameter int unsigned MAX_DESCS  = 256,
  parameter int unsigned DESC_BYTES = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [2:0]               cfg_idx_i,
  input  logic [63:0]              cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  sgfd_pkg::sgfd_in_t       in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output sgfd_pkg::sgfd_out_t      out_data_o
);
  import sgfd_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_DESCS + 1);
  localparam int unsigned OffW = $clog2((MAX_DESCS + 1) * DESC_BYTES + 1);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_SKIP,
    PH_EMIT,
    PH_DONE
  } phase_e;

  logic [31:0] card_base_q, start_offset_q, total_length_q;
  logic [12:0] plane_width_q;
  logic        chroma_plane_q;
  logic [63:0] slot0_q;

  phase_e      phase_q, phase_d;
  logic [31:0] skip_left_q, skip_left_d;
  logic [31:0] bytes_left_q, bytes_left_d;
  logic [31:0] card_cursor_q, card_cursor_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [OffW-1:0] next_off_q, next_off_d;

  sgfd_in_t  in_q;
  logic      in_vld_q;
  sgfd_out_t out_q, out_d;
  logic      out_vld_q;
  logic      res_d;
  logic      adv;

  phase_e      ph;
  logic [31:0] skip, bytes, cursor, off, seglen;
  logic [CntW-1:0] cnt;
  logic [OffW-1:0] noff;
  logic        last;
  logic [7:0]  lines;

  assign adv         = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o  = in_vld_q && out_vld_q && out_stall_i;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      card_base_q    <= '0;
      start_offset_q <= '0;
      total_length_q <= '0;
      plane_width_q  <= '0;
      chroma_plane_q <= 1'b0;
      slot0_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CARD_BASE:    card_base_q    <= cfg_data_i[31:0];
        REG_START_OFFSET: start_offset_q <= cfg_data_i[31:0];
        REG_TOTAL_LENGTH: total_length_q <= cfg_data_i[31:0];
        REG_PLANE_WIDTH:  plane_width_q  <= cfg_data_i[12:0];
        REG_CHROMA_PLANE: chroma_plane_q <= cfg_data_i[0];
        REG_RING_BASE:    slot0_q        <= (cfg_data_i + RING_ALIGN) & ~RING_ALIGN;
        default: ;
      endcase
    end
  end

  always_comb begin
    ph     = in_q.first_seg ? PH_SKIP : phase_q;
    skip   = in_q.first_seg ? start_offset_q : skip_left_q;
    bytes  = in_q.first_seg ? total_length_q : bytes_left_q;
    cursor = in_q.first_seg ? card_base_q : card_cursor_q;
    cnt    = in_q.first_seg ? '0 : cnt_q;
    noff   = in_q.first_seg ? OffW'(DESC_BYTES) : next_off_q;
    lines  = chroma_plane_q ? LINES_CHROMA : LINES_LUMA;

    off    = (ph == PH_SKIP) ? skip : '0;
    seglen = in_q.seg_len - off;
    last   = seglen >= bytes;

    phase_d       = ph;
    skip_left_d   = skip;
    bytes_left_d  = bytes;
    card_cursor_d = cursor;
    cnt_d         = cnt;
    next_off_d    = noff;
    res_d         = 1'b0;
    out_d         = '0;

    if (ph == PH_SKIP || ph == PH_EMIT) begin
      if (ph == PH_SKIP && in_q.seg_len != '0 && skip >= in_q.seg_len) begin
        skip_left_d = skip - in_q.seg_len;
        if (in_q.table_end) begin
          res_d        = 1'b1;
          out_d.status = STATUS_SHORT;
          phase_d      = PH_DONE;
        end
      end else if (ph == PH_SKIP && in_q.seg_len == '0 && skip != '0) begin
        res_d        = 1'b1;
        out_d.status = STATUS_SHORT;
        phase_d      = PH_DONE;
      end else if (ph == PH_SKIP && bytes == '0) begin
        skip_left_d = '0;
        phase_d     = PH_DONE;
      end else if (cnt == CntW'(MAX_DESCS)) begin
        skip_left_d  = '0;
        res_d        = 1'b1;
        out_d.status = STATUS_OVERFLOW;
        phase_d      = PH_DONE;
      end else begin
        skip_left_d          = '0;
        res_d                = 1'b1;
        out_d.desc_valid     = 1'b1;
        out_d.desc_index     = 8'(cnt);
        out_d.desc_ctrl      = chroma_plane_q ? CTRL_CHROMA : CTRL_LUMA;
        out_d.desc_len       = last ? bytes : seglen;
        out_d.desc_host_addr = in_q.seg_addr + {32'd0, off};
        out_d.desc_card_addr = {4'd0, last, GEOM_SWAP, 8'd0, lines,
                                plane_width_q[12:5], cursor};
        out_d.desc_next      = last ? '0 : slot0_q + 64'(noff);
        out_d.desc_last      = last;
        out_d.status         = STATUS_OK;
        card_cursor_d        = cursor + (last ? bytes : seglen);
        bytes_left_d         = last ? '0 : bytes - seglen;
        cnt_d                = cnt + 1'b1;
        next_off_d           = noff + OffW'(DESC_BYTES);
        if (last) begin
          phase_d = PH_DONE;
        end else if (in_q.table_end) begin
          out_d.status = STATUS_SHORT;
          phase_d      = PH_DONE;
        end else begin
          phase_d = PH_EMIT;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q      <= 1'b0;
      out_vld_q     <= 1'b0;
      phase_q       <= PH_IDLE;
      skip_left_q   <= '0;
      bytes_left_q  <= '0;
      card_cursor_q <= '0;
      cnt_q         <= '0;
      next_off_q    <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q     <= res_d;
        phase_q       <= phase_d;
        skip_left_q   <= skip_left_d;
        bytes_left_q  <= bytes_left_d;
        card_cursor_q <= card_cursor_d;
        cnt_q         <= cnt_d;
        next_off_q    <= next_off_d;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
    if (adv && res_d) begin
      out_q <= out_d;
    end
  end

endmodule

// ----- tb/sg_frame_descriptor_builder_core_test.sv -----
`timescale 1ns / 1ps

module sg_frame_descriptor_builder_core_test;
  import sgfd_pkg::*;

  localparam int unsigned MaxDescs    = 256;
  localparam int unsigned DescBytes   = 32;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned CycleLimit  = 500_000;
  localparam logic [63:0] EndFlag     = 64'h0800_0000_0000_0000;

  typedef enum logic [1:0] {XF_IDLE, XF_SKIP, XF_EMIT, XF_DONE} xfer_phase_e;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic [2:0]  cfg_idx    = '0;
  logic [63:0] cfg_data   = '0;
  logic        in_valid   = 1'b0;
  sgfd_in_t    in_data    = '0;
  logic        out_stall  = 1'b0;
  logic        in_stall;
  logic        out_valid;
  sgfd_out_t   out_data;

  int unsigned src_idle_pct  = 0;
  int unsigned rcv_stall_pct = 0;
  int unsigned cycle_count   = 0;
  int unsigned fail_count    = 0;
  int unsigned sent_items    = 0;

  logic [31:0] card_base_r, start_offset_r, total_length_r;
  logic [12:0] plane_width_r;
  logic        chroma_r;
  logic [63:0] ring_base_r;

  xfer_phase_e xf_phase;
  logic [31:0] skip_left, bytes_left, card_cursor;
  int unsigned emitted_descs;

  sgfd_out_t   descriptor_q[$];

  sg_frame_descriptor_builder_core #(
    .MAX_DESCS (MaxDescs),
    .DESC_BYTES(DescBytes)
  ) i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < rcv_stall_pct);
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic sgfd_in_t scatter_word(logic [63:0] addr, logic [31:0] len,
                                            logic first, logic tend);
    sgfd_in_t w;
    w.seg_addr  = addr;
    w.seg_len   = len;
    w.first_seg = first;
    w.table_end = tend;
    return w;
  endfunction

  function automatic void push_error(logic [1:0] code);
    sgfd_out_t r;
    r        = '0;
    r.status = code;
    descriptor_q.push_back(r);
    xf_phase = XF_DONE;
  endfunction

  function automatic void build_descriptor(sgfd_in_t e, logic [31:0] in_elem);
    sgfd_out_t   r;
    logic [31:0] remain, n;
    logic        last;
    logic [63:0] slot0;
    logic [7:0]  lines;
    if (emitted_descs >= MaxDescs) begin
      push_error(STATUS_OVERFLOW);
      return;
    end
    remain = e.seg_len - in_elem;
    n      = (remain < bytes_left) ? remain : bytes_left;
    last   = (n == bytes_left);
    slot0  = (ring_base_r + RING_ALIGN) & ~RING_ALIGN;
    lines  = chroma_r ? LINES_CHROMA : LINES_LUMA;
    r                = '0;
    r.desc_valid     = 1'b1;
    r.desc_index     = 8'(emitted_descs);
    r.desc_ctrl      = chroma_r ? CTRL_CHROMA : CTRL_LUMA;
    r.desc_len       = n;
    r.desc_host_addr = e.seg_addr + {32'h0, in_elem};
    r.desc_card_addr = {32'h0, card_cursor}
                     | (64'(plane_width_r / 13'd32) << 32)
                     | (64'(lines) << 40)
                     | (64'(GEOM_SWAP) << 56)
                     | (last ? EndFlag : 64'h0);
    r.desc_next      = last ? 64'h0 : slot0 + 64'(emitted_descs + 1) * 64'(DescBytes);
    r.desc_last      = last;
    r.status         = STATUS_OK;
    card_cursor += n;
    bytes_left  -= n;
    emitted_descs++;
    if (last) begin
      xf_phase = XF_DONE;
    end else if (e.table_end) begin
      r.status = STATUS_SHORT;
      xf_phase = XF_DONE;
    end else begin
      xf_phase = XF_EMIT;
    end
    descriptor_q.push_back(r);
  endfunction

  function automatic void predict_element(sgfd_in_t e);
    logic [31:0] off;
    if (e.first_seg) begin
      skip_left     = start_offset_r;
      bytes_left    = total_length_r;
      card_cursor   = card_base_r;
      emitted_descs = 0;
      xf_phase      = XF_SKIP;
    end
    if (xf_phase == XF_SKIP) begin
      if (e.seg_len != 0 && skip_left >= e.seg_len) begin
        skip_left -= e.seg_len;
        if (e.table_end) push_error(STATUS_SHORT);
        return;
      end
      if (e.seg_len == 0 && skip_left != 0) begin
        push_error(STATUS_SHORT);
        return;
      end
      off       = skip_left;
      skip_left = '0;
      if (bytes_left == 0) begin
        xf_phase = XF_DONE;
        return;
      end
      build_descriptor(e, off);
    end else if (xf_phase == XF_EMIT) begin
      build_descriptor(e, 32'h0);
    end
  endfunction

  task automatic check_word(input sgfd_out_t got);
    sgfd_out_t exp;
    if (descriptor_q.size() == 0) begin
      $error("unexpected descriptor word %h", got);
      fail_count++;
      return;
    end
    exp = descriptor_q.pop_front();
    if (got.desc_valid !== exp.desc_valid) begin
      $error("desc_valid: expected %0h, got %0h", exp.desc_valid, got.desc_valid);
      fail_count++;
    end
    if (got.desc_index !== exp.desc_index) begin
      $error("desc_index: expected %0h, got %0h", exp.desc_index, got.desc_index);
      fail_count++;
    end
    if (got.desc_ctrl !== exp.desc_ctrl) begin
      $error("desc_ctrl: expected %0h, got %0h", exp.desc_ctrl, got.desc_ctrl);
      fail_count++;
    end
    if (got.desc_len !== exp.desc_len) begin
      $error("desc_len: expected %0h, got %0h", exp.desc_len, got.desc_len);
      fail_count++;
    end
    if (got.desc_host_addr !== exp.desc_host_addr) begin
      $error("desc_host_addr: expected %0h, got %0h", exp.desc_host_addr,
             got.desc_host_addr);
      fail_count++;
    end
    if (got.desc_card_addr !== exp.desc_card_addr) begin
      $error("desc_card_addr: expected %0h, got %0h", exp.desc_card_addr,
             got.desc_card_addr);
      fail_count++;
    end
    if (got.desc_next !== exp.desc_next) begin
      $error("desc_next: expected %0h, got %0h", exp.desc_next, got.desc_next);
      fail_count++;
    end
    if (got.desc_last !== exp.desc_last) begin
      $error("desc_last: expected %0h, got %0h", exp.desc_last, got.desc_last);
      fail_count++;
    end
    if (got.status !== exp.status) begin
      $error("status: expected %0h, got %0h", exp.status, got.status);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_word(out_data);
  end

  task automatic send_element(input sgfd_in_t e);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= e;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    predict_element(e);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (descriptor_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input sgfd_reg_e idx, input logic [63:0] v);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_CARD_BASE:    card_base_r    = v[31:0];
      REG_START_OFFSET: start_offset_r = v[31:0];
      REG_TOTAL_LENGTH: total_length_r = v[31:0];
      REG_PLANE_WIDTH:  plane_width_r  = v[12:0];
      REG_CHROMA_PLANE: chroma_r       = v[0];
      REG_RING_BASE:    ring_base_r    = v;
      default: ;
    endcase
  endtask

  task automatic program_regs(input logic [63:0] cb, so, tl, pw, cp, rb);
    write_reg(REG_CARD_BASE, cb);
    write_reg(REG_START_OFFSET, so);
    write_reg(REG_TOTAL_LENGTH, tl);
    write_reg(REG_PLANE_WIDTH, pw);
    write_reg(REG_CHROMA_PLANE, cp);
    write_reg(REG_RING_BASE, rb);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic program_random();
    logic [63:0] cb, so, tl, rb;
    cb = rand64();
    if ($urandom_range(3) == 0) cb[31:0] = 32'hFFFF_FF00 | 32'($urandom_range(255));
    case ($urandom_range(7))
      0:       so = '0;
      1:       so = rand64();
      default: so = 64'($urandom_range(200));
    endcase
    case ($urandom_range(9))
      0:       tl = '0;
      1:       tl = 64'hFFFF_FFFF;
      2:       tl = rand64();
      default: tl = 64'($urandom_range(400, 1));
    endcase
    rb = ($urandom_range(3) == 0) ? ~64'h0 - 64'($urandom_range(40)) : rand64();
    program_regs(cb, so, tl, rand64(), rand64(), rb);
  endtask

  function automatic logic [31:0] pick_seg_len();
    case ($urandom_range(19))
      0:       return '0;
      1:       return $urandom;
      2:       return 32'hFFFF_FFFF;
      default: return 32'($urandom_range(120, 1));
    endcase
  endfunction

  task automatic send_transfer();
    sgfd_in_t    e;
    int unsigned n_el;
    n_el = $urandom_range(12, 1);
    for (int i = 0; i < n_el; i++) begin
      e.seg_addr  = rand64();
      e.seg_len   = pick_seg_len();
      e.first_seg = (i == 0);
      e.table_end = (i == n_el - 1) && ($urandom_range(3) != 0);
      // inject noise
      if ($urandom_range(19) == 0) begin
        e.first_seg = 1'($urandom_range(1));
        e.table_end = 1'($urandom_range(1));
      end
      send_element(e);
      if ($urandom_range(39) == 0) begin
        wait_drained();
        if ($urandom_range(1) == 1) program_random();
      end
    end
  endtask

  task automatic test_plain_chain();
    program_regs(64'h1000, 64'h0, 64'd100, 64'd8191, 64'h0, 64'h1234_5678_9ABC_DEF1);
    send_element(scatter_word(64'hDEAD_BEEF, 32'd10, 1'b0, 1'b0));
    send_element(scatter_word(64'h0, 32'd40, 1'b1, 1'b0));
    send_element(scatter_word(~64'h0, 32'd40, 1'b0, 1'b0));
    send_element(scatter_word(64'h5555_AAAA_5555_AAAA, 32'd40, 1'b0, 1'b1));
    send_element(scatter_word(64'h77, 32'd10, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_skip_and_short_table();
    program_regs(64'hFFFF_FFF0, 64'd50, 64'd30, 64'h0, 64'h1, 64'h0);
    send_element(scatter_word(64'h100, 32'd30, 1'b1, 1'b0));
    send_element(scatter_word(64'h200, 32'd20, 1'b0, 1'b0));
    send_element(scatter_word(64'h300, 32'd0, 1'b0, 1'b0));
    // hold until the chain so far is out, then carry on
    wait_drained();
    send_element(scatter_word(64'h400, 32'd25, 1'b0, 1'b0));
    send_element(scatter_word(64'h500, 32'd10, 1'b0, 1'b1));
    send_element(scatter_word(64'h600, 32'd60, 1'b1, 1'b1));
    send_element(scatter_word(64'h700, 32'd0, 1'b1, 1'b0));
    send_element(scatter_word(64'h800, 32'd5, 1'b0, 1'b0));
    send_element(scatter_word(64'h900, 32'd50, 1'b1, 1'b1));
    wait_drained();
  endtask

  task automatic test_register_extremes();
    program_regs(64'h0, 64'hFFFF_FFFF, 64'h0, 64'h0, 64'h0, 64'h0);
    send_element(scatter_word(64'h1, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_element(scatter_word(64'h2, 32'd7, 1'b0, 1'b0));
    wait_drained();
    program_regs(~64'h0, 64'd3, ~64'h0, ~64'h0, ~64'h0, ~64'h0);
    send_element(scatter_word(~64'h0, 32'hFFFF_FFFF, 1'b1, 1'b0));
    send_element(scatter_word(64'h0, 32'hFFFF_FFFF, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_descriptor_overflow();
    program_regs(64'h0, 64'h0, 64'hFFFF_FFFF, 64'd640, 64'h0, 64'h1000);
    for (int i = 0; i <= MaxDescs; i++) begin
      send_element(scatter_word(rand64(), 32'($urandom_range(64, 1)), i == 0, 1'b0));
    end
    send_element(scatter_word(64'h0, 32'd1, 1'b0, 1'b0));
    wait_drained();
  endtask

  task automatic test_random_traffic(input int unsigned src_pct, input int unsigned rcv_pct);
    int unsigned start_count;
    src_idle_pct  = src_pct;
    rcv_stall_pct = rcv_pct;
    start_count   = sent_items;
    while (sent_items - start_count < 190) begin
      if ($urandom_range(3) == 0) begin
        wait_drained();
        program_random();
      end
      send_transfer();
    end
    wait_drained();
  endtask

  initial begin
    card_base_r    = '0;
    start_offset_r = '0;
    total_length_r = '0;
    plane_width_r  = '0;
    chroma_r       = 1'b0;
    ring_base_r    = '0;
    xf_phase       = XF_IDLE;
    skip_left      = '0;
    bytes_left     = '0;
    card_cursor    = '0;
    emitted_descs  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_plain_chain();
    test_skip_and_short_table();
    src_idle_pct  = 26;
    rcv_stall_pct = 26;
    test_register_extremes();
    test_descriptor_overflow();
    test_random_traffic(0, 0);
    test_random_traffic(76, 0);
    test_random_traffic(0, 76);
    test_random_traffic(26, 26);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
